[rtl/core/tun_pkg.sv]
// ----------------------------------------------------------------------------
// tun_pkg
// Widths and shared types of the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

	localparam int IW    = 16;          // vertex coordinate width
	localparam int NIN   = 9;           // coordinates per triangle
	localparam int EW    = IW + 1;      // edge component width
	localparam int XW    = 2 * EW + 1;  // signed cross component width
	localparam int CW    = XW - 1;      // cross magnitude width
	localparam int HW    = CW / 2;      // half of a magnitude
	localparam int SW    = 2 * CW;      // sum of squares width
	localparam int RW    = SW / 2;      // square root width
	localparam int RMW   = RW + 2;      // square root remainder width
	localparam int QW    = 15;          // quotient width, holds 1.0 in Q1.14
	localparam int DW    = CW + 1;      // divider remainder width
	localparam int OW    = 16;          // output component width
	localparam int NC    = 3;           // vector components

	typedef struct packed {
		logic [NC-1:0]         neg;
		logic [NC-1:0][CW-1:0] mag;
	} tun_vec_t;

endpackage

[rtl/core/tun_front.sv]
// ----------------------------------------------------------------------------
// tun_front
// Edges, cross product, component squares and their sum over five stages.
// ----------------------------------------------------------------------------
module tun_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [tun_pkg::NIN*tun_pkg::IW-1:0] in_data,
	output logic                               out_valid,
	output tun_pkg::tun_vec_t                  out_vec,
	output logic [tun_pkg::SW-1:0]             out_sum
);
	import tun_pkg::*;

	logic                          valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [NC-1:0][EW-1:0]  a_s1, b_s1;
	logic signed [NC-1:0][XW-1:0]  c_s2;
	tun_vec_t                      vec_s3, vec_s4, vec_s5;
	logic [NC-1:0][CW-1:0]         hh_s3, hl_s3, ll_s3;
	logic [NC-1:0][SW-1:0]         sq_s4;
	logic [SW-1:0]                 sum_s5;

	logic signed [NC-1:0][EW-1:0]  a_d, b_d;
	logic signed [NC-1:0][XW-1:0]  c_d;
	tun_vec_t                      vec_d;
	logic [NC-1:0][CW-1:0]         hh_d, hl_d, ll_d;
	logic [NC-1:0][SW-1:0]         sq_d;

	always_comb begin
		logic signed [EW-1:0]     p0, p1, p2;
		logic signed [2*EW-1:0]   m1, m2;
		logic [XW-1:0]            absv;
		logic [HW-1:0]            h, l;
		for (int i = 0; i < NC; i++) begin
			p0 = EW'($signed(in_data[i*IW +: IW]));
			p1 = EW'($signed(in_data[(i+3)*IW +: IW]));
			p2 = EW'($signed(in_data[(i+6)*IW +: IW]));
			a_d[i] = p2 - p0;
			b_d[i] = p1 - p0;
		end
		for (int i = 0; i < NC; i++) begin
			m1 = $signed(a_s1[(i+1)%NC]) * $signed(b_s1[(i+2)%NC]);
			m2 = $signed(a_s1[(i+2)%NC]) * $signed(b_s1[(i+1)%NC]);
			c_d[i] = XW'(m1) - XW'(m2);
		end
		for (int i = 0; i < NC; i++) begin
			absv = c_s2[i][XW-1] ? XW'(-c_s2[i]) : XW'(c_s2[i]);
			vec_d.neg[i] = c_s2[i][XW-1];
			vec_d.mag[i] = absv[CW-1:0];
			h = absv[CW-1:HW];
			l = absv[HW-1:0];
			hh_d[i] = h * h;
			hl_d[i] = h * l;
			ll_d[i] = l * l;
		end
		for (int i = 0; i < NC; i++) begin
			sq_d[i] = (SW'(hh_s3[i]) << (2*HW)) + (SW'(hl_s3[i]) << (HW+1))
				+ SW'(ll_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a_d;
			b_s1   <= b_d;
			c_s2   <= c_d;
			vec_s3 <= vec_d;
			hh_s3  <= hh_d;
			hl_s3  <= hl_d;
			ll_s3  <= ll_d;
			vec_s4 <= vec_s3;
			sq_s4  <= sq_d;
			vec_s5 <= vec_s4;
			sum_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2];
		end
	end

	assign out_valid = valid_s5;
	assign out_vec   = vec_s5;
	assign out_sum   = sum_s5;

endmodule

[rtl/core/tun_sqrt.sv]
// ----------------------------------------------------------------------------
// tun_sqrt
// Floor square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module tun_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  tun_pkg::tun_vec_t      in_vec,
	input  logic [tun_pkg::SW-1:0] in_sum,
	output logic                   out_valid,
	output tun_pkg::tun_vec_t      out_vec,
	output logic [tun_pkg::RW-1:0] out_root
);
	import tun_pkg::*;

	logic                valid_s [0:RW];
	tun_vec_t            vec_s   [0:RW];
	logic [SW-1:0]       sum_s   [0:RW];
	logic [RMW-1:0]      rem_s   [0:RW];
	logic [RW-1:0]       root_s  [0:RW];

	assign valid_s[0] = in_valid;
	assign vec_s[0]   = in_vec;
	assign sum_s[0]   = in_sum;
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int B = RW - 1 - k;
		logic [RMW+1:0] cur, trial, nrem;
		logic           ge;

		always_comb begin
			cur   = {rem_s[k], sum_s[k][2*B+1 -: 2]};
			trial = {2'b00, root_s[k], 2'b01};
			ge    = cur >= trial;
			nrem  = ge ? cur - trial : cur;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[k+1]  <= vec_s[k];
				sum_s[k+1]  <= sum_s[k];
				rem_s[k+1]  <= nrem[RMW-1:0];
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
			end
		end
	end

	assign out_valid = valid_s[RW];
	assign out_vec   = vec_s[RW];
	assign out_root  = root_s[RW];

endmodule

[rtl/core/tun_div.sv]
// ----------------------------------------------------------------------------
// tun_div
// Three-lane restoring divider of each magnitude scaled by 2^14 by the root.
// ----------------------------------------------------------------------------
module tun_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  tun_pkg::tun_vec_t                 in_vec,
	input  logic [tun_pkg::RW-1:0]            in_root,
	output logic                              out_valid,
	output logic [tun_pkg::NC-1:0]            out_neg,
	output logic                              out_zero,
	output logic [tun_pkg::NC-1:0][tun_pkg::QW-1:0] out_quot
);
	import tun_pkg::*;

	logic                   valid_s [0:QW];
	logic [NC-1:0]          neg_s   [0:QW];
	logic [RW-1:0]          div_s   [0:QW];
	logic [NC-1:0][DW-1:0]  rem_s   [0:QW];
	logic [NC-1:0][QW-1:0]  quot_s  [0:QW];

	assign valid_s[0] = in_valid;
	assign neg_s[0]   = in_vec.neg;
	assign div_s[0]   = in_root;
	assign quot_s[0]  = '0;
	always_comb begin
		for (int i = 0; i < NC; i++) begin
			rem_s[0][i] = DW'(in_vec.mag[i]);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [NC-1:0][DW-1:0] nrem;
		logic [NC-1:0][QW-1:0] nquot;

		always_comb begin
			logic [DW-1:0] d;
			logic          ge;
			for (int i = 0; i < NC; i++) begin
				ge       = rem_s[k][i] >= DW'(div_s[k]);
				d        = ge ? rem_s[k][i] - DW'(div_s[k]) : rem_s[k][i];
				nrem[i]  = {d[DW-2:0], 1'b0};
				nquot[i] = {quot_s[k][i][QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k+1]  <= neg_s[k];
				div_s[k+1]  <= div_s[k];
				rem_s[k+1]  <= nrem;
				quot_s[k+1] <= nquot;
			end
		end
	end

	assign out_valid = valid_s[QW];
	assign out_neg   = neg_s[QW];
	assign out_zero  = div_s[QW] == '0;
	assign out_quot  = quot_s[QW];

endmodule

[rtl/core/triangle_unit_normal.sv]
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle in signed Q1.14.
// ----------------------------------------------------------------------------
// The block accepts one triangle per clock and returns its normal through
// five stages for edges, cross product and sum of squares, one stage
// per bit for the 34-bit square root, one per quotient bit for the 15-bit
// divider, and the output register. A stall on the output side holds the
// whole pipeline, and a degenerate triangle returns a zero vector with the
// flag in tuser set.
module triangle_unit_normal (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// norm_x, norm_y, norm_z
	output logic [47:0]  m_axis_tdata,
	// degenerate
	output logic [0:0]   m_axis_tuser
);
	import tun_pkg::*;

	logic                  en;
	logic                  fr_valid, sq_valid, dv_valid, dv_zero;
	tun_vec_t              fr_vec, sq_vec;
	logic [SW-1:0]         fr_sum;
	logic [RW-1:0]         sq_root;
	logic [NC-1:0]         dv_neg;
	logic [NC-1:0][QW-1:0] dv_quot;
	logic                  out_valid_q;
	logic [NC-1:0][OW-1:0] out_norm_q;
	logic                  out_degen_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	tun_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.in_data   (s_axis_tdata),
		.out_valid (fr_valid),
		.out_vec   (fr_vec),
		.out_sum   (fr_sum)
	);

	tun_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_vec    (fr_vec),
		.in_sum    (fr_sum),
		.out_valid (sq_valid),
		.out_vec   (sq_vec),
		.out_root  (sq_root)
	);

	tun_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_vec    (sq_vec),
		.in_root   (sq_root),
		.out_valid (dv_valid),
		.out_neg   (dv_neg),
		.out_zero  (dv_zero),
		.out_quot  (dv_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_degen_q <= dv_zero;
			for (int i = 0; i < NC; i++) begin
				if (dv_zero) begin
					out_norm_q[i] <= '0;
				end else if (dv_neg[i]) begin
					out_norm_q[i] <= OW'(-OW'(dv_quot[i]));
				end else begin
					out_norm_q[i] <= OW'(dv_quot[i]);
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_norm_q;
	assign m_axis_tuser  = out_degen_q;

endmodule

[tb/sv/tb_triangle_unit_normal.sv]
// ----------------------------------------------------------------------------
// tb_triangle_unit_normal
// Self-checking testbench for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
// Triangles are sent as stream transfers, first a directed set of extremes
// and degenerate shapes, then random full-range, small, collinear, near-limit
// and repeated-vertex triangles. Each accepted triangle is run through a
// local integer model whose result waits in a queue until the block returns
// the matching transfer. Both sides idle in random bursts, the sender twice
// waits for the pipeline to drain, and the closing part runs with no idling.
module tb_triangle_unit_normal;
	import tun_pkg::*;

	typedef struct {
		logic signed [OW-1:0] nx, ny, nz;
		logic                 degen;
	} normal_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [47:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	normal_t normals_due[$];
	int      mismatches;
	int      ready_idle;
	bit      calm;

	triangle_unit_normal uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [OW-1:0] scale_q14(longint c, longint m);
		longint q;
		q = (c * 16384) / m;
		if (q > 16384) q = 16384;
		if (q < -16384) q = -16384;
		return q[OW-1:0];
	endfunction

	function automatic normal_t face_normal(logic [143:0] d);
		longint p[9];
		longint ax, ay, az, bx, by, bz, cx, cy, cz;
		logic [127:0] sum, cand;
		longint m;
		normal_t r;
		for (int i = 0; i < 9; i++) p[i] = $signed(d[i*16 +: 16]);
		ax = p[6] - p[0]; ay = p[7] - p[1]; az = p[8] - p[2];
		bx = p[3] - p[0]; by = p[4] - p[1]; bz = p[5] - p[2];
		cx = ay * bz - az * by;
		cy = az * bx - ax * bz;
		cz = ax * by - ay * bx;
		sum = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
		m = 0;
		for (int i = 36; i >= 0; i--) begin
			cand = 128'(m | (longint'(1) << i));
			if (cand * cand <= sum) m = cand[63:0];
		end
		if (m == 0) begin
			r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
		end else begin
			r.nx = scale_q14(cx, m);
			r.ny = scale_q14(cy, m);
			r.nz = scale_q14(cz, m);
			r.degen = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (calm || ready_idle == 0) begin
			m_axis_tready <= 1'b1;
			if (!calm && $urandom_range(0, 7) == 0) ready_idle = $urandom_range(1, 5);
		end else begin
			m_axis_tready <= 1'b0;
			ready_idle--;
		end
	end

	always @(posedge clk) begin
		normal_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (normals_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer %h", m_axis_tdata);
			end else begin
				e = normals_due.pop_front();
				if (m_axis_tdata !== {e.nz, e.ny, e.nx} || m_axis_tuser[0] !== e.degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %0d %0d deg %0d, got %0d %0d %0d deg %0d",
							e.nx, e.ny, e.nz, e.degen,
							$signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
							$signed(m_axis_tdata[47:32]), m_axis_tuser[0]);
				end
			end
		end
	end

	task automatic send_triangle(logic [143:0] d);
		int gap;
		s_axis_tdata  <= d;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		normals_due.push_back(face_normal(d));
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [143:0] pack9(int c[9]);
		logic [143:0] d;
		for (int i = 0; i < 9; i++) d[i*16 +: 16] = c[i][15:0];
		return d;
	endfunction

	task automatic test_directed();
		send_triangle('0);
		send_triangle(pack9('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
		send_triangle(pack9('{0, 0, 0, 0, 1, 0, 1, 0, 0}));
		send_triangle(pack9('{0, 0, 0, 0, 0, 1, 1, 0, 0}));
		send_triangle(pack9('{5, 5, 5, 5, 5, 5, 5, 5, 5}));
		send_triangle(pack9('{0, 0, 0, 1, 1, 1, 2, 2, 2}));
		send_triangle(pack9('{-32768, -32768, -32768, 32767, -32768, -32768,
			-32768, 32767, -32768}));
		send_triangle(pack9('{32767, 32767, 32767, -32768, 32767, 32767,
			32767, -32768, 32767}));
		send_triangle(pack9('{-32768, -32768, -32768, 32767, 32767, 32767,
			-32768, -32768, 32767}));
		send_triangle(pack9('{-32768, 32767, -32768, 32767, -32768, 32767,
			32767, 32767, -32768}));
		send_triangle(pack9('{-32768, -32768, -32768, -32768, -32768, -32768,
			32767, 32767, 32767}));
		send_triangle(pack9('{1, 2, 3, 4, 6, 9, 7, 10, 15}));
		send_triangle(pack9('{0, 0, 0, 3, 4, 0, 0, 0, 1}));
		send_triangle('1);
		send_triangle({9{16'h8000}});
		send_triangle({9{16'h7fff}});
	endtask

	task automatic test_random(int n);
		int c[9];
		int k;
		for (int t = 0; t < n; t++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: for (int i = 0; i < 9; i++) c[i] = $urandom_range(0, 65535) - 32768;
				4, 5: for (int i = 0; i < 9; i++) c[i] = $urandom_range(0, 64) - 32;
				6: begin
					for (int i = 0; i < 6; i++) c[i] = $urandom_range(0, 200) - 100;
					k = $urandom_range(0, 6) - 3;
					for (int i = 0; i < 3; i++) c[6+i] = c[i] + k * (c[3+i] - c[i]);
				end
				7: begin
					for (int i = 0; i < 9; i++) c[i] = $urandom_range(0, 65535) - 32768;
					for (int i = 0; i < 3; i++) c[3+3*$urandom_range(0, 1)+i] = c[i];
				end
				default: for (int i = 0; i < 9; i++)
					c[i] = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
						: -32768 + $urandom_range(0, 3);
			endcase
			send_triangle(pack9(c));
		end
	endtask

	task automatic test_drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (normals_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		mismatches    = 0;
		ready_idle    = 0;
		calm          = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(800);
		test_drain();
		test_random(600);
		calm = 1'b1;
		test_random(250);
		test_drain();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && normals_due.size() == 0) begin
			$display("tb_triangle_unit_normal passed");
		end else begin
			$display("tb_triangle_unit_normal failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_triangle_unit_normal failed");
		$finish;
	end

endmodule

[sim.f]
rtl/core/tun_pkg.sv
rtl/core/tun_front.sv
rtl/core/tun_sqrt.sv
rtl/core/tun_div.sv
rtl/core/triangle_unit_normal.sv
tb/sv/tb_triangle_unit_normal.sv
